/* hdl/ccte_pkg.sv */
package ccte_pkg;

    // field widths of the request and response beats
    localparam int FRAME_W  = 24;
    localparam int CAM_W    = 16;
    localparam int BLEN_W   = 16;
    localparam int CURVE_W  = 2;
    localparam int IDX_W    = 6;
    localparam int COUNT_W  = 7;
    localparam int HEAD_W   = 32;
    localparam int MODE_W   = 2;
    localparam int WEIGHT_W = 17;

    // divider: numerator is (t - F) << 8, quotient is the raw 16-bit weight
    localparam int NUM_W = 32;
    localparam int QUO_W = 16;

    localparam int DEF_MAX_CUTS = 64;

    // opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // blend curves
    localparam logic [CURVE_W-1:0] CURVE_EASE_OUT = 2'd2;

    // result modes
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEFORE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BLEND  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_HARD   = 2'd3;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

    // one table entry as stored in the cut memory
    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [CAM_W-1:0]   from_cam;
        logic [CAM_W-1:0]   to_cam;
        logic [BLEN_W-1:0]  blen;
        logic [CURVE_W-1:0] curve;
    } t_cut;

endpackage

/* hdl/ccte_req_if.sv */
interface ccte_req_if;
    import ccte_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic [IDX_W-1:0]         entry_index;
    logic [FRAME_W-1:0]       start_frame_in;
    logic [CAM_W-1:0]         from_camera_in;
    logic [CAM_W-1:0]         to_camera_in;
    logic [BLEN_W-1:0]        blend_len_in;
    logic [CURVE_W-1:0]       curve_in;
    logic signed [HEAD_W-1:0] play_head;

    modport source (
        output valid, opcode, entry_index, start_frame_in, from_camera_in,
               to_camera_in, blend_len_in, curve_in, play_head,
        input  ready
    );

    modport sink (
        input  valid, opcode, entry_index, start_frame_in, from_camera_in,
               to_camera_in, blend_len_in, curve_in, play_head,
        output ready
    );

endinterface

/* hdl/ccte_rsp_if.sv */
interface ccte_rsp_if;
    import ccte_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [CAM_W-1:0]    camera_a;
    logic [CAM_W-1:0]    camera_b;
    logic [WEIGHT_W-1:0] blend_weight;
    logic                blend_on;

    modport source (
        output valid, mode, camera_a, camera_b, blend_weight, blend_on,
        input  ready
    );

    modport sink (
        input  valid, mode, camera_a, camera_b, blend_weight, blend_on,
        output ready
    );

endinterface

/* hdl/ccte_cut_mem.sv */
module ccte_cut_mem #(
    parameter int MAX_CUTS = ccte_pkg::DEF_MAX_CUTS,
    parameter int AW       = (MAX_CUTS > 1) ? $clog2(MAX_CUTS) : 1
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  ccte_pkg::t_cut  i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output ccte_pkg::t_cut  o_rdata
);
    import ccte_pkg::*;

    t_cut r_mem [MAX_CUTS];
    t_cut r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/ccte_div.sv */
module ccte_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ccte_pkg::NUM_W-1:0]    i_num,
    input  logic [ccte_pkg::BLEN_W-1:0]   i_den,
    output logic                          o_done,
    output logic [ccte_pkg::QUO_W-1:0]    o_quo
);
    import ccte_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);

    // numerator < den * 2^16, so the upper half starts as remainder
    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [BLEN_W-1:0]    r_rem;
    logic [QUO_W-1:0]     r_low;
    logic [QUO_W-1:0]     r_quo;
    logic [BLEN_W-1:0]    r_den;
    logic [BLEN_W:0]      w_trial;
    logic [BLEN_W:0]      w_diff;
    logic                 w_ge;

    // one restoring step per cycle
    assign w_trial = {r_rem, r_low[QUO_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[NUM_W-1:QUO_W];
            r_low <= i_num[QUO_W-1:0];
            r_den <= i_den;
            r_cnt <= CNT_W'(QUO_W - 1);
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[BLEN_W-1:0] : w_trial[BLEN_W-1:0];
            r_low <= {r_low[QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* hdl/camera_cut_timeline_eval_core.sv */
// Write beat: stored in the cut memory on acceptance if its index is below MAX_CUTS.
// Query beat: one table scan of n = min(cut count, MAX_CUTS) entries through the
//   single memory read port (one entry a cycle), then, inside a blend window, a 16-step
//   serial divider; no scan with no cuts. One item at a time.
// Reset (i_rst_n low, synchronous): cut count cleared, FSM idle, output empty.
// Table contents are not cleared; entries read as undefined until written.
module camera_cut_timeline_eval_core #(
    parameter int MAX_CUTS = ccte_pkg::DEF_MAX_CUTS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ccte_pkg::COUNT_W-1:0]   i_cfg_wdata,
    ccte_req_if.sink                       i_req,
    ccte_rsp_if.source                     o_rsp
);
    import ccte_pkg::*;

    localparam int AW = (MAX_CUTS > 1) ? $clog2(MAX_CUTS) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_SHAPE = 3'd4;
    localparam logic [2:0] S_WGT   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]              r_state;
    logic [COUNT_W-1:0]      r_num_cuts;
    logic [COUNT_W-1:0]      w_n;
    logic                    w_req_beat;
    logic                    w_rsp_beat;

    // scan bookkeeping
    logic [COUNT_W-1:0]      r_issue;
    logic                    r_dv;
    logic [COUNT_W-1:0]      r_didx;
    logic signed [HEAD_W-1:0] r_t;
    logic [FRAME_W-1:0]      r_min_frame;
    logic [CAM_W-1:0]        r_min_from;
    t_cut                    r_best;
    logic                    r_found;
    t_cut                    w_rd;
    t_cut                    w_wdata;
    logic                    w_mem_we;
    logic                    w_qual;

    // evaluation
    logic signed [HEAD_W:0]  w_t33;
    logic signed [HEAD_W:0]  w_min_f;
    logic signed [HEAD_W+1:0] w_t34;
    logic signed [HEAD_W+1:0] w_blend_end;
    logic [HEAD_W:0]         w_diff;
    logic                    w_before;
    logic                    w_in_blend;
    logic                    w_div_start;
    logic [NUM_W-1:0]        w_div_num;
    logic                    w_div_done;
    logic [QUO_W-1:0]        w_div_quo;
    logic [QUO_W-1:0]        r_raw;
    logic [2*WEIGHT_W-1:0]   r_sq;
    logic [WEIGHT_W-1:0]     w_u;

    // pending result and output register
    logic [MODE_W-1:0]       r_res_mode;
    logic [CAM_W-1:0]        r_res_a;
    logic [CAM_W-1:0]        r_res_b;
    logic [WEIGHT_W-1:0]     r_res_w;
    logic                    r_res_act;
    logic                    w_out_load;
    logic                    r_out_valid;
    logic [MODE_W-1:0]       r_out_mode;
    logic [CAM_W-1:0]        r_out_a;
    logic [CAM_W-1:0]        r_out_b;
    logic [WEIGHT_W-1:0]     r_out_w;
    logic                    r_out_act;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_req_beat  = i_req.valid && i_req.ready;
    assign w_rsp_beat  = r_out_valid && o_rsp.ready;
    assign w_out_load  = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    // effective count, clamped to table depth
    assign w_n = (32'(r_num_cuts) > MAX_CUTS) ? COUNT_W'(MAX_CUTS) : r_num_cuts;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cuts <= '0;
        end else if (i_cfg_we) begin
            r_num_cuts <= i_cfg_wdata;
        end
    end

    // table write on a write beat
    assign w_mem_we = w_req_beat && (i_req.opcode == OP_WRITE)
                      && (32'(i_req.entry_index) < MAX_CUTS);
    assign w_wdata  = '{frame:    i_req.start_frame_in,
                        from_cam: i_req.from_camera_in,
                        to_cam:   i_req.to_camera_in,
                        blen:     i_req.blend_len_in,
                        curve:    i_req.curve_in};

    ccte_cut_mem #(
        .MAX_CUTS (MAX_CUTS),
        .AW       (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (AW'(i_req.entry_index)),
        .i_wdata (w_wdata),
        .i_raddr (AW'(r_issue)),
        .o_rdata (w_rd)
    );

    // compares in 33/34-bit signed space
    assign w_t33       = $signed({r_t[HEAD_W-1], r_t});
    assign w_t34       = $signed({{2{r_t[HEAD_W-1]}}, r_t});
    assign w_qual      = $signed({1'b0, w_rd.frame, 8'b0}) <= w_t33;
    assign w_min_f     = $signed({1'b0, r_min_frame, 8'b0});
    assign w_before    = w_t33 < w_min_f;
    assign w_blend_end = $signed({2'b0, r_best.frame, 8'b0}
                                 + {{(HEAD_W+2-BLEN_W-8){1'b0}}, r_best.blen, 8'b0});
    assign w_in_blend  = (r_best.blen != '0) && (w_t34 < w_blend_end);
    assign w_diff      = w_t33 - $signed({1'b0, r_best.frame, 8'b0});
    assign w_div_num   = {w_diff[NUM_W-9:0], 8'b0};
    assign w_div_start = (r_state == S_EVAL) && !w_before && w_in_blend;

    ccte_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_best.blen),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    assign w_u = WEIGHT_ONE - {1'b0, r_raw};

    // control FSM
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_dv        <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (w_rsp_beat) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_dv <= 1'b0;
                    if (w_req_beat && (i_req.opcode == OP_QUERY)) begin
                        r_state <= (w_n == '0) ? S_DONE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_dv <= (r_issue < w_n);
                    if ((r_issue == w_n) && !r_dv) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (w_before || !w_in_blend) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_SHAPE;
                    end
                end
                S_SHAPE: r_state <= S_WGT;
                S_WGT:   r_state <= S_DONE;
                S_DONE: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_req_beat) begin
            r_t        <= i_req.play_head;
            r_issue    <= '0;
            r_found    <= 1'b0;
            r_res_mode <= MODE_NONE;
            r_res_a    <= '0;
            r_res_b    <= '0;
            r_res_w    <= '0;
            r_res_act  <= 1'b0;
        end

        // issue one read per cycle, fold the returned entry
        if (r_state == S_SCAN) begin
            if (r_issue < w_n) begin
                r_issue <= r_issue + 1'b1;
                r_didx  <= r_issue;
            end
            if (r_dv) begin
                if ((r_didx == '0) || (w_rd.frame < r_min_frame)) begin
                    r_min_frame <= w_rd.frame;
                    r_min_from  <= w_rd.from_cam;
                end
                if (w_qual && (!r_found || (w_rd.frame >= r_best.frame))) begin
                    r_best  <= w_rd;
                    r_found <= 1'b1;
                end
            end
        end

        // choose the mode
        if (r_state == S_EVAL) begin
            if (w_before) begin
                r_res_mode <= MODE_BEFORE;
                r_res_a    <= r_min_from;
            end else if (w_in_blend) begin
                r_res_mode <= MODE_BLEND;
                r_res_a    <= r_best.from_cam;
                r_res_b    <= r_best.to_cam;
                r_res_act  <= 1'b1;
            end else begin
                r_res_mode <= MODE_HARD;
                r_res_a    <= r_best.to_cam;
            end
        end

        if ((r_state == S_DIV) && w_div_done) begin
            r_raw <= w_div_quo;
        end

        // ease-out square, registered before the final subtract
        if (r_state == S_SHAPE) begin
            r_sq <= {{WEIGHT_W{1'b0}}, w_u} * {{WEIGHT_W{1'b0}}, w_u};
        end

        if (r_state == S_WGT) begin
            if (r_best.curve == CURVE_EASE_OUT) begin
                r_res_w <= WEIGHT_ONE - r_sq[WEIGHT_W+15:16];
            end else begin
                r_res_w <= {1'b0, r_raw};
            end
        end

        // output register load
        if (w_out_load) begin
            r_out_mode <= r_res_mode;
            r_out_a    <= r_res_a;
            r_out_b    <= r_res_b;
            r_out_w    <= r_res_w;
            r_out_act  <= r_res_act;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.mode         = r_out_mode;
    assign o_rsp.camera_a     = r_out_a;
    assign o_rsp.camera_b     = r_out_b;
    assign o_rsp.blend_weight = r_out_w;
    assign o_rsp.blend_on     = r_out_act;

`ifndef SYNTHESIS
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");

    a_scan_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && r_dv |-> (r_didx < w_n))
        else $error("scan returned entry beyond cut count");

    a_active_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.blend_on == (o_rsp.mode == MODE_BLEND)))
        else $error("blend flag disagrees with mode");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.blend_weight <= WEIGHT_ONE))
        else $error("blend weight above one");

    a_eval_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) && !w_before |-> r_found)
        else $error("no selected cut after scan");
`endif

endmodule
